@@ rtl/mbd_pkg.sv @@
// ----------------------------------------------------------------------------
// mbd_pkg: shared types and constants for the mipmap box downsampler
// Pixel beat layouts, config register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package mbd_pkg;

    localparam int CHAN_W      = 8;
    localparam int PART_W      = 7;
    localparam int NUM_CHAN    = 4;
    localparam int CFG_W       = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int MAX_DIM_DEF = 2048;
    localparam int STORE_W     = PART_W * NUM_CHAN;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic [CHAN_W-1:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
        logic              last_out;
    } pixel_out_t;

endpackage

`default_nettype wire

@@ rtl/mbd_line_store.sv @@
// ----------------------------------------------------------------------------
// mbd_line_store: line buffer of even-row partial sums
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_line_store #(
    parameter int DEPTH  = mbd_pkg::MAX_DIM_DEF / 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [mbd_pkg::STORE_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic      [mbd_pkg::STORE_W-1:0] rd_data
);

    logic [mbd_pkg::STORE_W-1:0] mem [DEPTH];
    logic [mbd_pkg::STORE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // holds its value until the next read, so a stalled consumer sees stable data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/mipmap_box_downsample_top.sv @@
// ----------------------------------------------------------------------------
// mipmap_box_downsample_top: next-level mipmap generator for RGBA8 streams
// Pixels arrive in raster order on the in channel (valid/stall); one
// downsampled pixel leaves on the out channel per 2x2 quad (or per pixel
// pair when the image is one pixel wide or high; a 1x1 image passes as is).
// last_out marks the final pixel of the output level.
// Config: write image_width / image_height through cfg_write, cfg_index,
// cfg_data while idle; a width or height write restarts the frame at column 0, row 0.
// Throughput: one input beat per cycle while in_stall is low. The input beat
// that completes an output beat is registered in the middle stage (with the
// line store read) and then in the output register.
// The line store keeps one entry per column pair; the even-row partial sum
// is written on the even-row beat and read back on the odd-row beat.
// Stall: when out_stall holds a full output register, the middle stage
// fills and then in_stall rises; no beat is dropped.
// Reset: counters, held pixel and both stages clear; width and height go
// to 2. The line store needs no clearing, every read follows its write.
// ----------------------------------------------------------------------------
`default_nettype none

module mipmap_box_downsample_top #(
    parameter int MAX_DIM = mbd_pkg::MAX_DIM_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [mbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [mbd_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire mbd_pkg::pixel_in_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output mbd_pkg::pixel_out_t                   out_data
);

    localparam int DEPTH  = (MAX_DIM + 1) / 2;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(MAX_DIM);
    localparam int DW     = $clog2(MAX_DIM + 1);
    localparam int CH     = mbd_pkg::CHAN_W;
    localparam int PW     = mbd_pkg::PART_W;
    localparam int NC     = mbd_pkg::NUM_CHAN;

    // config
    logic [mbd_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [DW-1:0]             w_c, h_c;
    logic [31:0]               w_ext, h_ext;

    // frame position and held pixel
    logic [CW-1:0]             col_reg, col_next;
    logic [CW-1:0]             row_reg, row_next;
    logic [NC-1:0][CH-1:0]     held_reg;
    logic [NC-1:0][CH-1:0]     cur;

    // middle stage
    logic                      s1_valid_reg;
    logic                      s1_mem_reg;
    logic                      s1_last_reg;
    logic [NC-1:0][CH-1:0]     s1_res_reg;

    // output register
    logic                      out_valid_reg;
    mbd_pkg::pixel_out_t       out_data_reg;

    logic                      accept, s1_adv, out_free;
    logic                      quad, line1d;
    logic                      produce, last_c;
    logic [NC-1:0][CH-1:0]     res_c;
    logic                      wr_en, rd_en;
    logic [ADDR_W-1:0]         slot;
    logic [mbd_pkg::STORE_W-1:0] wr_data, rd_data;
    logic [CW-1:0]             p;
    logic [DW-1:0]             n, n_end, w_end, h_end;
    logic [NC-1:0][CH-1:0]     mid_res;

    assign cur[0] = in_data.red_in;
    assign cur[1] = in_data.green_in;
    assign cur[2] = in_data.blue_in;
    assign cur[3] = in_data.alpha_in;

    // clamp registers to [1, MAX_DIM]
    always_comb
    begin
        w_ext = 32'(width_reg);
        h_ext = 32'(height_reg);
        if (w_ext == 32'd0)
        begin
            w_ext = 32'd1;
        end
        else if (w_ext > 32'(MAX_DIM))
        begin
            w_ext = 32'(MAX_DIM);
        end
        if (h_ext == 32'd0)
        begin
            h_ext = 32'd1;
        end
        else if (h_ext > 32'(MAX_DIM))
        begin
            h_ext = 32'(MAX_DIM);
        end
        w_c = DW'(w_ext);
        h_c = DW'(h_ext);
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign quad   = (w_c > DW'(1)) && (h_c > DW'(1));
    assign line1d = !quad && ((w_c > DW'(1)) || (h_c > DW'(1)));
    assign p      = (w_c > DW'(1)) ? col_reg : row_reg;
    assign n      = (w_c > DW'(1)) ? w_c : h_c;
    // index of the last paired column/row
    assign n_end  = {n[DW-1:1], 1'b0} - DW'(1);
    assign w_end  = {w_c[DW-1:1], 1'b0} - DW'(1);
    assign h_end  = {h_c[DW-1:1], 1'b0} - DW'(1);

    assign slot = ADDR_W'(col_reg >> 1);

    always_comb
    begin
        produce = 1'b0;
        last_c  = 1'b0;
        res_c   = '0;
        wr_data = '0;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        for (int k = 0; k < NC; k++)
        begin
            wr_data[k*PW +: PW] = PW'({2'b00, held_reg[k][CH-1:2]} + {2'b00, cur[k][CH-1:2]});
        end
        if (quad)
        begin
            if (col_reg[0] && !row_reg[0])
            begin
                wr_en = accept;
            end
            else if (col_reg[0] && row_reg[0])
            begin
                rd_en   = accept;
                produce = 1'b1;
                last_c  = (DW'(row_reg) == h_end) && (DW'(col_reg) == w_end);
                // quarter sums of the odd row; the stored even row is added later
                for (int k = 0; k < NC; k++)
                begin
                    res_c[k] = CH'(wr_data[k*PW +: PW]);
                end
            end
        end
        else if (line1d)
        begin
            if (p[0])
            begin
                produce = 1'b1;
                last_c  = (DW'(p) == n_end);
                for (int k = 0; k < NC; k++)
                begin
                    res_c[k] = {1'b0, held_reg[k][CH-1:1]} + {1'b0, cur[k][CH-1:1]};
                end
            end
        end
        else
        begin
            produce = 1'b1;
            last_c  = 1'b1;
            res_c   = cur;
        end
    end

    // next position in the frame
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if ((DW'(col_reg) + DW'(1)) >= w_c)
        begin
            col_next = '0;
            row_next = ((DW'(row_reg) + DW'(1)) >= h_c) ? '0 : row_reg + CW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mbd_pkg::CFG_W'(2);
            height_reg <= mbd_pkg::CFG_W'(2);
            col_reg    <= '0;
            row_reg    <= '0;
            held_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                if ((quad && !col_reg[0]) || (line1d && !p[0]))
                begin
                    held_reg <= cur;
                end
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    mbd_pkg::CFG_IMAGE_WIDTH:
                    begin
                        width_reg <= cfg_data;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    mbd_pkg::CFG_IMAGE_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    mbd_line_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (slot),
        .rd_data (rd_data)
    );

    // middle stage: holds the beat while the registered line store read is made
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept && produce)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            s1_mem_reg  <= quad;
            s1_last_reg <= last_c;
            s1_res_reg  <= res_c;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            mid_res[k] = s1_mem_reg ? (CH'(rd_data[k*PW +: PW]) + s1_res_reg[k]) : s1_res_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg.red_out   <= mid_res[0];
            out_data_reg.green_out <= mid_res[1];
            out_data_reg.blue_out  <= mid_res[2];
            out_data_reg.alpha_out <= mid_res[3];
            out_data_reg.last_out  <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("line store read and write in the same cycle");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        DW'(col_reg) < w_c)
        else $error("column counter beyond image width");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index == mbd_pkg::CFG_IMAGE_WIDTH ||
                      cfg_index == mbd_pkg::CFG_IMAGE_HEIGHT)
        |=> col_reg == '0 && row_reg == '0)
        else $error("config write did not restart the frame");

    a_mid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_stall |=> out_valid_reg)
        else $error("middle stage beat not moved to output");
`endif

endmodule

`default_nettype wire

@@ test/tb_mipmap_box_downsample_top.sv @@
// ----------------------------------------------------------------------------
// tb_mipmap_box_downsample_top: self-checking bench for the mipmap downsampler
// Streams RGBA8 pixels through the block under several image sizes and
// handshake patterns. A behavioral predictor works out each downsampled
// pixel as input beats are taken, and every output beat is checked against
// the oldest expected pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mipmap_box_downsample_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbd_pkg::*;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int WIDE_ITEMS     = 512;
    localparam int STALL_PCT      = 71;
    localparam int BOTH_PCT       = 35;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int FINAL_LIMIT    = 2000;
    localparam int PAIR_SLOTS     = MAX_DIM_DEF / 2;

    // indexes past the register list; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idling_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    pixel_in_t              in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    pixel_out_t             out_data;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_off       = 1'b0;
    int unsigned hold_count = 0;

    pixel_in_t  pending_pixels[$];
    pixel_out_t expected_pixels[$];
    int unsigned pushed_pixels   = 0;
    int unsigned accepted_pixels = 0;
    int unsigned checked_results = 0;
    int unsigned reg_writes      = 0;
    int unsigned error_count     = 0;
    int unsigned quiet_cycles    = 0;

    // predictor state
    logic [CFG_W-1:0]  level_width  = 12'd2;
    logic [CFG_W-1:0]  level_height = 12'd2;
    pixel_in_t         pair_px      = '0;
    int unsigned       col_at       = 0;
    int unsigned       row_at       = 0;
    logic [PART_W-1:0] top_row_sums [PAIR_SLOTS][NUM_CHAN];

    mipmap_box_downsample_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM_DEF)
            return MAX_DIM_DEF;
        return 32'(v);
    endfunction

    function automatic void predict_downsample(pixel_in_t px);
        int unsigned w;
        int unsigned h;
        int unsigned slot;
        int unsigned pos;
        int unsigned span;
        logic [CHAN_W-1:0] cur [NUM_CHAN];
        logic [CHAN_W-1:0] prev [NUM_CHAN];
        logic [CHAN_W-1:0] sum [NUM_CHAN];
        logic is_last;
        bit produced;
        w = clamp_dim(level_width);
        h = clamp_dim(level_height);
        cur = '{px.red_in, px.green_in, px.blue_in, px.alpha_in};
        prev = '{pair_px.red_in, pair_px.green_in, pair_px.blue_in, pair_px.alpha_in};
        sum = '{default: '0};
        is_last = 1'b0;
        produced = 1'b0;
        if (w > 1 && h > 1)
        begin
            slot = col_at / 2;
            if (col_at % 2 == 0)
                pair_px = px;
            else if (row_at % 2 == 0)
            begin
                for (int k = 0; k < NUM_CHAN; k++)
                    top_row_sums[slot][k] = PART_W'((prev[k] >> 2) + (cur[k] >> 2));
            end
            else
            begin
                for (int k = 0; k < NUM_CHAN; k++)
                    sum[k] = top_row_sums[slot][k] + (prev[k] >> 2) + (cur[k] >> 2);
                is_last = (row_at == 2 * (h / 2) - 1) && (col_at == 2 * (w / 2) - 1);
                produced = 1'b1;
            end
        end
        else if (w > 1 || h > 1)
        begin
            // single row or single column: pair along the long side
            pos  = (w > 1) ? col_at : row_at;
            span = (w > 1) ? w : h;
            if (pos % 2 == 0)
                pair_px = px;
            else
            begin
                for (int k = 0; k < NUM_CHAN; k++)
                    sum[k] = (prev[k] >> 1) + (cur[k] >> 1);
                is_last = (pos == 2 * (span / 2) - 1);
                produced = 1'b1;
            end
        end
        else
        begin
            sum = cur;
            is_last = 1'b1;
            produced = 1'b1;
        end

        if (col_at + 1 >= w)
        begin
            col_at = 0;
            row_at = (row_at + 1 >= h) ? 0 : row_at + 1;
        end
        else
            col_at = col_at + 1;

        if (produced)
            expected_pixels.push_back('{red_out: sum[0], green_out: sum[1],
                blue_out: sum[2], alpha_out: sum[3], last_out: is_last});
    endfunction

    function automatic logic [CHAN_W-1:0] pick_byte();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return CHAN_W'($urandom_range(255));
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(11))
            0: return 12'd0;
            1: return 12'd1;
            2: return 12'd2;
            3: return 12'd3;
            default: return CFG_W'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic push_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                              logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a);
        pending_pixels.push_back('{red_in: r, green_in: g, blue_in: b, alpha_in: a});
        pushed_pixels++;
    endtask

    task automatic queue_random(int unsigned count);
        repeat (count)
            push_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        reg_writes++;
        if (idx == CFG_IMAGE_WIDTH || idx == CFG_IMAGE_HEIGHT)
        begin
            if (idx == CFG_IMAGE_WIDTH)
                level_width = val;
            else
                level_height = val;
            col_at = 0;
            row_at = 0;
        end
    endtask

    task automatic set_idling(idling_t mode);
        send_idle_pct  <= (mode == IDLE_SEND) ? STALL_PCT : (mode == IDLE_BOTH) ? BOTH_PCT : 0;
        recv_stall_pct <= (mode == IDLE_RECV) ? STALL_PCT : (mode == IDLE_BOTH) ? BOTH_PCT : 0;
    endtask

    // all beats taken, all results seen, then room for beats that make no result
    task automatic wait_drained();
        while (accepted_pixels != pushed_pixels || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // pixel source
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data  <= pending_pixels.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result sink; the one long hold-off stretch is timed here
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off && hold_count < HOLD_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_count++;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        pixel_out_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_downsample(in_data);
                accepted_pixels++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("output beat with no pixel expected: %h", out_data);
                    error_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    checked_results++;
                    if (out_data.red_out !== want.red_out)
                    begin
                        $error("red_out: expected %0d, got %0d", want.red_out, out_data.red_out);
                        error_count++;
                    end
                    if (out_data.green_out !== want.green_out)
                    begin
                        $error("green_out: expected %0d, got %0d",
                               want.green_out, out_data.green_out);
                        error_count++;
                    end
                    if (out_data.blue_out !== want.blue_out)
                    begin
                        $error("blue_out: expected %0d, got %0d",
                               want.blue_out, out_data.blue_out);
                        error_count++;
                    end
                    if (out_data.alpha_out !== want.alpha_out)
                    begin
                        $error("alpha_out: expected %0d, got %0d",
                               want.alpha_out, out_data.alpha_out);
                        error_count++;
                    end
                    if (out_data.last_out !== want.last_out)
                    begin
                        $error("last_out: expected %0d, got %0d",
                               want.last_out, out_data.last_out);
                        error_count++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
            $display("tb_mipmap_box_downsample_top NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;
        int unsigned frame_px;
        int unsigned split;
        int unsigned random_start;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size is 2x2: single quads with extreme channels
        set_idling(IDLE_NONE);
        repeat (4) push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        repeat (4) push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
        push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
        push_pixel(8'h80, 8'h7F, 8'h01, 8'hFE);
        push_pixel(8'h03, 8'h04, 8'hFC, 8'h02);
        wait_drained();

        // 1x1 pass-through, then zero sizes which act as 1
        write_reg(CFG_IMAGE_WIDTH, 12'd1);
        write_reg(CFG_IMAGE_HEIGHT, 12'd1);
        push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
        push_pixel(8'hFF, 8'h00, 8'hA5, 8'h5A);
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 12'd0);
        write_reg(CFG_IMAGE_HEIGHT, 12'd0);
        push_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        wait_drained();

        // odd single row: the third pixel is dropped
        write_reg(CFG_IMAGE_WIDTH, 12'd3);
        push_pixel(8'hFF, 8'hFF, 8'h01, 8'h00);
        push_pixel(8'hFF, 8'h01, 8'hFF, 8'h00);
        push_pixel(8'h77, 8'h88, 8'h99, 8'hAA);
        wait_drained();

        // odd single column, then spare indexes must not restart the frame
        write_reg(CFG_IMAGE_WIDTH, 12'd1);
        write_reg(CFG_IMAGE_HEIGHT, 12'd3);
        push_pixel(8'hFE, 8'h01, 8'h80, 8'h7F);
        wait_drained();
        write_reg(CFG_SPARE_A, 12'hFFF);
        write_reg(CFG_SPARE_B, 12'h000);
        push_pixel(8'h01, 8'hFE, 8'h7F, 8'h80);
        push_pixel(8'hC3, 8'h3C, 8'h00, 8'hFF);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        wait_drained();

        // output held off long enough for the block to back up its input
        write_reg(CFG_IMAGE_HEIGHT, 12'd1);
        hold_off <= 1'b1;
        queue_random(48);
        wait_drained();
        hold_off <= 1'b0;

        random_start = pushed_pixels;
        while (pushed_pixels - random_start < RANDOM_ITEMS)
        begin
            set_idling(idling_t'($urandom_range(3)));
            w_val = pick_dim();
            h_val = pick_dim();
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom));
            if ($urandom_range(1))
            begin
                write_reg(CFG_IMAGE_WIDTH, w_val);
                write_reg(CFG_IMAGE_HEIGHT, h_val);
            end
            else
            begin
                write_reg(CFG_IMAGE_HEIGHT, h_val);
                write_reg(CFG_IMAGE_WIDTH, w_val);
            end
            frame_px = clamp_dim(w_val) * clamp_dim(h_val);
            queue_random($urandom_range(1, 3) * frame_px);
            // sometimes a partial frame, resumed after an ignored write or abandoned
            if ($urandom_range(2) == 0)
            begin
                split = $urandom_range(1, frame_px);
                queue_random(split);
                if (split < frame_px && $urandom_range(1))
                begin
                    wait_drained();
                    write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B,
                              CFG_W'($urandom));
                    queue_random(frame_px - split);
                end
            end
            wait_drained();
        end

        // oversized width clamps to the widest level; a long partial row
        set_idling(IDLE_BOTH);
        write_reg(CFG_IMAGE_WIDTH, 12'hFFF);
        write_reg(CFG_IMAGE_HEIGHT, 12'd0);
        queue_random(WIDE_ITEMS);

        while (accepted_pixels != pushed_pixels)
            @(posedge clk);
        for (int c = 0; c < FINAL_LIMIT && expected_pixels.size() != 0; c++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $error("%0d expected pixels never came out", expected_pixels.size());
            error_count++;
        end

        $display("run: %0d pixels in, %0d downsampled pixels checked, %0d register writes",
                 accepted_pixels, checked_results, reg_writes);
        $display("run: 1x1, row, column and quad levels, odd and clamped sizes, back-pressure");
        if (error_count == 0)
            $display("tb_mipmap_box_downsample_top OK");
        else
            $display("tb_mipmap_box_downsample_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
